### rtl/core/sahit_pkg.sv
package sahit_pkg;

  // Field formats
  localparam int CW     = 32;       // coordinate width, signed
  localparam int TW     = 32;       // fraction width, unsigned
  localparam int FF     = 24;       // fraction bits of a fraction
  localparam int FS     = TW - FF;  // integer bits of a fraction
  localparam int NW     = CW + 1;   // slab distance magnitude
  localparam int PRW    = TW + CW;  // fraction times coordinate product
  localparam int PSW    = PRW + 1;  // signed entry point coordinate
  localparam int PLIM_B = 60;       // product magnitude clamp exponent

  localparam int NAXES   = 3;
  localparam int DIV_LAT = TW + 1;  // divider register levels
  localparam int QDEPTH  = 2;
  localparam int QPW     = $clog2(QDEPTH);
  localparam int AW      = 5;       // paddr width
  localparam int DW      = 32;      // APB data width

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-2:0]        half_t;
  typedef logic [TW-1:0]        frac_t;
  typedef logic signed [CW:0]   bound_t;
  typedef logic [NW-1:0]        num_t;
  typedef logic [CW-1:0]        den_t;
  typedef logic [1:0]           axis_t;
  typedef logic [2:0]           reg_idx_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam reg_idx_t REG_START_X = 3'd0;
  localparam reg_idx_t REG_START_Y = 3'd1;
  localparam reg_idx_t REG_START_Z = 3'd2;
  localparam reg_idx_t REG_DELTA_X = 3'd3;
  localparam reg_idx_t REG_DELTA_Y = 3'd4;
  localparam reg_idx_t REG_DELTA_Z = 3'd5;
  localparam reg_idx_t REG_WANT    = 3'd6;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    half_t  half_size_x;
    half_t  half_size_y;
    half_t  half_size_z;
    frac_t  best_fraction;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    logic   start_inside;
    frac_t  new_fraction;
    axis_t  face_axis;
    logic   face_negative;
    logic   contact_valid;
    coord_t contact_x;
    coord_t contact_y;
    coord_t contact_z;
  } out_item_t;

  typedef struct packed {
    coord_t [NAXES-1:0] start;
    coord_t [NAXES-1:0] delta;
    logic               want_contact;
  } cfg_t;

  // Classification that travels with a box through the divider
  typedef struct packed {
    bound_t [NAXES-1:0] lo;
    bound_t [NAXES-1:0] hi;
    frac_t              best;
    logic               start_in;
    logic [NAXES-1:0]   neg;
    logic [NAXES-1:0]   cand;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    num_t [NAXES-1:0] num;
    den_t [NAXES-1:0] den;
  } q_entry_t;

  function automatic den_t coord_mag(coord_t v);
    den_t m;
    m = v[CW-1] ? (~den_t'(v) + den_t'(1)) : den_t'(v);
    return m;
  endfunction

endpackage

### rtl/core/sahit_front.sv
module sahit_front (
  input  sahit_pkg::in_item_t in_item,
  input  sahit_pkg::cfg_t     cfg,
  output sahit_pkg::q_entry_t entry
);
  import sahit_pkg::*;

  coord_t [NAXES-1:0] c;
  half_t  [NAXES-1:0] h;
  bound_t [NAXES-1:0] lo;
  bound_t [NAXES-1:0] hi;
  bound_t [NAXES-1:0] s;
  logic signed [CW+1:0] dlo [NAXES];
  logic signed [CW+1:0] dhi [NAXES];
  logic [NAXES-1:0] neg;
  logic [NAXES-1:0] pos;

  assign c = {in_item.center_z, in_item.center_y, in_item.center_x};
  assign h = {in_item.half_size_z, in_item.half_size_y, in_item.half_size_x};

  always_comb begin
    entry = '0;
    for (int i = 0; i < NAXES; i++) begin
      lo[i]  = (CW+1)'(c[i]) - $signed({2'b00, h[i]});
      hi[i]  = (CW+1)'(c[i]) + $signed({2'b00, h[i]});
      s[i]   = (CW+1)'(cfg.start[i]);
      neg[i] = $signed(s[i]) < $signed(lo[i]);
      pos[i] = $signed(s[i]) > $signed(hi[i]);
      dlo[i] = (CW+2)'($signed(lo[i])) - (CW+2)'($signed(s[i]));
      dhi[i] = (CW+2)'($signed(s[i])) - (CW+2)'($signed(hi[i]));
      entry.num[i]       = neg[i] ? dlo[i][NW-1:0] : dhi[i][NW-1:0];
      entry.den[i]       = coord_mag(cfg.delta[i]);
      entry.meta.lo[i]   = lo[i];
      entry.meta.hi[i]   = hi[i];
      entry.meta.neg[i]  = neg[i];
      // entering a slab needs motion toward it
      entry.meta.cand[i] = (neg[i] && !cfg.delta[i][CW-1] && (cfg.delta[i] != '0)) ||
                           (pos[i] && cfg.delta[i][CW-1]);
    end
    entry.meta.best     = in_item.best_fraction;
    entry.meta.start_in = ~|(neg | pos);
  end

endmodule

### rtl/core/sahit_queue.sv
module sahit_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sahit_pkg::q_entry_t push_data,
  input  logic                pop,
  output sahit_pkg::q_entry_t pop_data,
  output logic                full,
  output logic                empty
);
  import sahit_pkg::*;

  q_entry_t         mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPW+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH-1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH-1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && !full |=> !empty)
    else $error("queue lost a word");

endmodule

### rtl/core/sahit_div.sv
module sahit_div (
  input  logic            clk,
  input  sahit_pkg::num_t num,
  input  sahit_pkg::den_t den,
  output sahit_pkg::frac_t quo
);
  import sahit_pkg::*;

  localparam int STEPS = TW;

  logic [CW:0]   rem_r [0:STEPS];
  logic [TW-1:0] low_r [0:STEPS];
  logic [TW-1:0] quo_r [0:STEPS];
  den_t          den_r [0:STEPS];
  logic          ovf_r [0:STEPS];

  // load: quotient of num * 2^FF / den, saturated when it needs more than TW bits
  always_ff @(posedge clk) begin
    rem_r[0] <= num >> FS;
    low_r[0] <= {num[FS-1:0], {FF{1'b0}}};
    quo_r[0] <= '0;
    den_r[0] <= den;
    ovf_r[0] <= {{FS{1'b0}}, num} >= {1'b0, den, {FS{1'b0}}};
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [CW:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1][CW-1:0], low_r[k-1][TW-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? (trial - {1'b0, den_r[k-1]}) : trial;
      low_r[k] <= {low_r[k-1][TW-2:0], 1'b0};
      quo_r[k] <= {quo_r[k-1][TW-2:0], ge};
      den_r[k] <= den_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo = ovf_r[STEPS] ? '1 : quo_r[STEPS];

endmodule

### rtl/core/sahit_back.sv
module sahit_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sahit_pkg::cfg_t      cfg,
  input  logic                 pop,
  input  sahit_pkg::q_entry_t  entry,
  output logic                 out_valid,
  output sahit_pkg::out_item_t out_item
);
  import sahit_pkg::*;

  localparam logic [PRW-1:0] PLIM = PRW'(1) << PLIM_B;
  localparam logic signed [PSW-1:0] CMAX = PSW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [PSW-1:0] CMIN = -CMAX - PSW'(1);

  frac_t [NAXES-1:0] tq;
  meta_t             meta_r [DIV_LAT];
  logic              vld_r  [DIV_LAT];

  for (genvar i = 0; i < NAXES; i++) begin : g_div
    sahit_div u_div (
      .clk (clk),
      .num (entry.num[i]),
      .den (entry.den[i]),
      .quo (tq[i])
    );
  end

  // carry classification alongside the divider
  always_ff @(posedge clk) begin
    meta_r[0] <= entry.meta;
    for (int k = 1; k < DIV_LAT; k++) begin
      meta_r[k] <= meta_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= pop;
      for (int k = 1; k < DIV_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // select the latest entry; ties keep the lower axis
  meta_t md;
  logic  found;
  axis_t sel;
  frac_t tsel;

  assign md = meta_r[DIV_LAT-1];

  always_comb begin
    found = 1'b0;
    sel   = AXIS_X;
    tsel  = '0;
    for (int i = 0; i < NAXES; i++) begin
      if (md.cand[i] && (!found || tq[i] > tsel)) begin
        found = 1'b1;
        sel   = axis_t'(i);
        tsel  = tq[i];
      end
    end
  end

  logic  s1_vld_r, s2_vld_r, s3_vld_r;
  meta_t s1_meta_r, s2_meta_r, s3_meta_r;
  logic  s1_found_r, s2_found_r, s3_found_r;
  axis_t s1_sel_r, s2_sel_r, s3_sel_r;
  frac_t s1_t_r, s2_t_r, s3_t_r;
  logic [PRW-1:0]          prod_r [NAXES];
  logic signed [PSW-1:0]   pt_r   [NAXES];
  logic [PRW-1:0]          mq     [NAXES];
  logic [PRW-1:0]          mc     [NAXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_r[DIV_LAT-1];
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      mq[i] = prod_r[i] >> FF;
      mc[i] = (mq[i] > PLIM) ? PLIM : mq[i];
    end
  end

  always_ff @(posedge clk) begin
    s1_meta_r  <= md;
    s1_found_r <= found;
    s1_sel_r   <= sel;
    s1_t_r     <= tsel;
    s2_meta_r  <= s1_meta_r;
    s2_found_r <= s1_found_r;
    s2_sel_r   <= s1_sel_r;
    s2_t_r     <= s1_t_r;
    s3_meta_r  <= s2_meta_r;
    s3_found_r <= s2_found_r;
    s3_sel_r   <= s2_sel_r;
    s3_t_r     <= s2_t_r;
    for (int i = 0; i < NAXES; i++) begin
      prod_r[i] <= PRW'(s1_t_r) * PRW'(coord_mag(cfg.delta[i]));
      pt_r[i]   <= PSW'(cfg.start[i]) +
                   (cfg.delta[i][CW-1] ? -$signed({1'b0, mc[i]}) : $signed({1'b0, mc[i]}));
    end
  end

  // final checks and result word
  logic      in_slab [NAXES];
  logic      ok;
  out_item_t res;
  coord_t    cp [NAXES];

  always_comb begin
    ok = s3_found_r && (s3_t_r < s3_meta_r.best);
    for (int i = 0; i < NAXES; i++) begin
      in_slab[i] = (pt_r[i] >= PSW'($signed(s3_meta_r.lo[i]))) &&
                   (pt_r[i] <= PSW'($signed(s3_meta_r.hi[i])));
      if (axis_t'(i) != s3_sel_r && !in_slab[i]) begin
        ok = 1'b0;
      end
      if (pt_r[i] > CMAX) begin
        cp[i] = CMAX[CW-1:0];
      end else if (pt_r[i] < CMIN) begin
        cp[i] = CMIN[CW-1:0];
      end else begin
        cp[i] = pt_r[i][CW-1:0];
      end
    end
    res = '0;
    res.new_fraction = s3_meta_r.best;
    if (s3_meta_r.start_in) begin
      res.hit          = 1'b1;
      res.start_inside = 1'b1;
    end else if (ok) begin
      res.hit           = 1'b1;
      res.new_fraction  = s3_t_r;
      res.face_axis     = s3_sel_r;
      res.face_negative = s3_meta_r.neg[s3_sel_r];
      if (cfg.want_contact) begin
        res.contact_valid = 1'b1;
        res.contact_x     = cp[0];
        res.contact_y     = cp[1];
        res.contact_z     = cp[2];
      end
    end
  end

  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> ##(DIV_LAT+4) out_valid_r)
    else $error("word did not reach the result port in time");

  a_inside_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.start_inside |-> out_item_r.hit && !out_item_r.contact_valid)
    else $error("start inside result malformed");

  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.hit |-> !out_item_r.contact_valid && !out_item_r.face_negative)
    else $error("miss result carries hit fields");

endmodule

### rtl/core/segment_aabox_hit_test.sv
// Result path: a result strobe (out_valid) lasts one cycle; the receiver cannot stall it.
//   Each box passes the queue, the divider levels, stages s1 to s3 and the result register.
// Throughput: one box per cycle; the 33-level radix-2 divider pipeline per axis sets depth.
// busy rises only if the two-word queue fills, which the free-running back end prevents.
// Reset (rst_n, synchronous, active low) clears the registers, the queue and all
//   pipeline valid flags; data registers hold no reset.
module segment_aabox_hit_test (
  input  logic                           clk,
  input  logic                           rst_n,
  // box channel
  input  logic                           start,
  output logic                           busy,
  input  sahit_pkg::in_item_t            in_item,
  // result channel
  output logic                           out_valid,
  output sahit_pkg::out_item_t           out_item,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sahit_pkg::AW-1:0]       paddr,
  input  logic [sahit_pkg::DW-1:0]       pwdata,
  output logic [sahit_pkg::DW-1:0]       prdata,
  output logic                           pready
);
  import sahit_pkg::*;

  // Registers: segment start, segment direction, contact enable
  coord_t [NAXES-1:0] start_r, start_nxt;
  coord_t [NAXES-1:0] delta_r, delta_nxt;
  logic               want_r, want_nxt;
  reg_idx_t           idx;
  logic               wr_en;
  cfg_t               cfg;

  assign pready = 1'b1;
  assign idx    = paddr[AW-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    start_nxt = start_r;
    delta_nxt = delta_r;
    want_nxt  = want_r;
    if (wr_en) begin
      case (idx)
        REG_START_X: start_nxt[0] = pwdata[CW-1:0];
        REG_START_Y: start_nxt[1] = pwdata[CW-1:0];
        REG_START_Z: start_nxt[2] = pwdata[CW-1:0];
        REG_DELTA_X: delta_nxt[0] = pwdata[CW-1:0];
        REG_DELTA_Y: delta_nxt[1] = pwdata[CW-1:0];
        REG_DELTA_Z: delta_nxt[2] = pwdata[CW-1:0];
        REG_WANT:    want_nxt     = pwdata[0];
        default:     ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      delta_r <= '0;
      want_r  <= 1'b0;
    end else begin
      start_r <= start_nxt;
      delta_r <= delta_nxt;
      want_r  <= want_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_START_X: prdata = DW'(start_r[0]);
      REG_START_Y: prdata = DW'(start_r[1]);
      REG_START_Z: prdata = DW'(start_r[2]);
      REG_DELTA_X: prdata = DW'(delta_r[0]);
      REG_DELTA_Y: prdata = DW'(delta_r[1]);
      REG_DELTA_Z: prdata = DW'(delta_r[2]);
      REG_WANT:    prdata = DW'(want_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.start        = start_r;
  assign cfg.delta        = delta_r;
  assign cfg.want_contact = want_r;

  // Front end: bounds, slab sides and divider operands for each box
  q_entry_t front_entry;
  q_entry_t head;
  logic     q_full, q_empty, push, pop;

  sahit_front u_front (
    .in_item (in_item),
    .cfg     (cfg),
    .entry   (front_entry)
  );

  assign busy = q_full;
  assign push = start && !q_full;
  // the back end never stalls: advance whenever a word waits
  assign pop  = !q_empty;

  sahit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .pop       (pop),
    .pop_data  (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: divide, pick the entry face, check the other slabs, form the result
  sahit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop       (pop),
    .entry     (head),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
